// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and helper functions for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Input word: one message byte or an end-of-message marker
  typedef struct packed {
    logic       kind;       // 0: data byte, 1: end of message
    logic [7:0] data_byte;
  } in_word_t;

  // Output word: one digest byte
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last;
  } out_word_t;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LastPos    = 6'd63;
  localparam logic [5:0] LenPos     = 6'd56;
  localparam logic [5:0] LastRound  = 6'd63;
  localparam logic [3:0] LastDigest = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,   // taking message bytes
    ST_PAD,    // writing pad / length bytes, one per cycle
    ST_LOAD,   // first word read, working regs loaded
    ST_ROUND,  // 64 compression rounds
    ST_FOLD,   // add working regs into chaining words
    ST_EMIT    // stream out 16 digest bytes
  } md5_state_e;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmt [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by a round
  function automatic logic [3:0] word_idx(input logic [5:0] rnd);
    logic [3:0] k;
    logic [3:0] idx;
    k = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = k;
      2'd1:    idx = 4'((k << 2) + k + 4'd1);
      2'd2:    idx = 4'((k << 1) + k + 4'd5);
      default: idx = 4'((k << 3) - k);
    endcase
    return idx;
  endfunction

  // Round mixing function
  function automatic logic [31:0] mix_fn(input logic [1:0] phase,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    unique case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

endpackage

// ===== rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 over a byte stream: block store in a word memory, one round per cycle.
// ----------------------------------------------------------------------------
// Usage: send message bytes as words with kind = 0, then one word with
// kind = 1 to close the message; the block answers with 16 digest bytes,
// the last one flagged. Data bytes are accepted back to back; the 64th
// byte of a block starts a compression (load, 64 rounds, fold), with no
// input taken meanwhile. After the end word come pad and length bytes up
// to the block end and one compression (two when the length does not fit
// behind the pad byte), then the digest bytes while output is ready. The
// message block lives in a 16 x 32-bit memory with byte writes and a
// registered read; the next round's message word is fetched in the round
// before, so the round loop runs without bubbles. The chaining words and
// the 61-bit byte count sit in flops and return to their initial values
// after each digest, so messages follow back to back. A new message byte
// is taken as soon as the last digest byte is registered.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output md5_pkg::out_word_t out_word_o
);

  // Block store: 16 little-endian message words
  logic [31:0] mem_q [16];
  logic [31:0] rdata_q;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [3:0]  rd_addr;

  md5_pkg::md5_state_e state_q, state_d;

  logic [5:0]  pos_q;        // next free byte in the block
  logic [60:0] byte_cnt_q;   // message length in bytes (bits mod 2^64)
  logic        padding_q;    // end word seen, finishing the message
  logic        spill_q;      // length goes into an extra block
  logic [5:0]  rnd_q;
  logic [3:0]  emit_cnt_q;
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic        out_valid_q;
  md5_pkg::out_word_t out_q;

  logic        in_acc;
  logic        emit_load;
  logic [63:0] bit_cnt;
  logic [7:0]  len_byte;
  logic [31:0] round_sum;
  logic [31:0] round_b;

  assign in_acc    = in_valid_i && in_ready_o;
  assign emit_load = (state_q == md5_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign bit_cnt   = {byte_cnt_q, 3'b000};
  assign len_byte  = bit_cnt[{pos_q[2:0], 3'b000} +: 8];

  // One MD5 round on the word fetched last cycle
  assign round_sum = a_q + md5_pkg::mix_fn(rnd_q[5:4], b_q, c_q, d_q)
                   + md5_pkg::RoundK[rnd_q] + rdata_q;
  assign round_b   = b_q + md5_pkg::rotl(round_sum,
                                         md5_pkg::RotAmt[{rnd_q[5:4], rnd_q[1:0]}]);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pos_q == md5_pkg::LastPos) begin
            state_d = md5_pkg::ST_LOAD;
          end else if (in_word_i.kind == md5_pkg::KindEnd) begin
            state_d = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (pos_q == md5_pkg::LastPos) begin
          state_d = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_LOAD:  state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: begin
        if (rnd_q == md5_pkg::LastRound) begin
          state_d = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        priority if (!padding_q) begin
          state_d = md5_pkg::ST_IDLE;
        end else if (spill_q) begin
          state_d = md5_pkg::ST_PAD;
        end else begin
          state_d = md5_pkg::ST_EMIT;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (emit_load && emit_cnt_q == md5_pkg::LastDigest) begin
          state_d = md5_pkg::ST_IDLE;
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs / memory control ----------------
  always_comb begin
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = 8'h00;
    rd_addr    = md5_pkg::word_idx(6'(rnd_q + 6'd1));
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        wr_en      = in_valid_i;
        wr_data    = (in_word_i.kind == md5_pkg::KindEnd) ? md5_pkg::PadByte
                                                          : in_word_i.data_byte;
      end
      md5_pkg::ST_PAD: begin
        wr_en   = 1'b1;
        wr_data = (pos_q >= md5_pkg::LenPos && !spill_q) ? len_byte : 8'h00;
      end
      md5_pkg::ST_LOAD:  rd_addr = md5_pkg::word_idx(6'd0);
      md5_pkg::ST_ROUND,
      md5_pkg::ST_FOLD,
      md5_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------- block memory ----------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // ---------------- control and datapath ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_pkg::ST_IDLE;
      pos_q       <= '0;
      byte_cnt_q  <= '0;
      padding_q   <= 1'b0;
      spill_q     <= 1'b0;
      rnd_q       <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      chain_q[0]  <= md5_pkg::Iv0;
      chain_q[1]  <= md5_pkg::Iv1;
      chain_q[2]  <= md5_pkg::Iv2;
      chain_q[3]  <= md5_pkg::Iv3;
    end else begin
      state_q     <= state_d;
      // held until taken, reloaded while emitting
      out_valid_q <= emit_load || (out_valid_q && !out_ready_i);
      unique case (state_q)
        md5_pkg::ST_IDLE: begin
          if (in_acc) begin
            pos_q <= 6'(pos_q + 6'd1);
            if (in_word_i.kind == md5_pkg::KindEnd) begin
              padding_q <= 1'b1;
              spill_q   <= (pos_q >= md5_pkg::LenPos);
            end else begin
              byte_cnt_q <= 61'(byte_cnt_q + 61'd1);
            end
          end
        end
        md5_pkg::ST_PAD: pos_q <= 6'(pos_q + 6'd1);
        md5_pkg::ST_LOAD: begin
          rnd_q <= '0;
          a_q   <= chain_q[0];
          b_q   <= chain_q[1];
          c_q   <= chain_q[2];
          d_q   <= chain_q[3];
        end
        md5_pkg::ST_ROUND: begin
          rnd_q <= 6'(rnd_q + 6'd1);
          a_q   <= d_q;
          b_q   <= round_b;
          c_q   <= b_q;
          d_q   <= c_q;
        end
        md5_pkg::ST_FOLD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          spill_q    <= 1'b0;
          emit_cnt_q <= '0;
        end
        md5_pkg::ST_EMIT: begin
          if (emit_load) begin
            out_q.digest_byte <= chain_q[emit_cnt_q[3:2]][{emit_cnt_q[1:0], 3'b000} +: 8];
            out_q.last        <= (emit_cnt_q == md5_pkg::LastDigest);
            emit_cnt_q        <= 4'(emit_cnt_q + 4'd1);
            if (emit_cnt_q == md5_pkg::LastDigest) begin
              // back to the initial chain for the next message
              padding_q  <= 1'b0;
              pos_q      <= '0;
              byte_cnt_q <= '0;
              chain_q[0] <= md5_pkg::Iv0;
              chain_q[1] <= md5_pkg::Iv1;
              chain_q[2] <= md5_pkg::Iv2;
              chain_q[3] <= md5_pkg::Iv3;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == md5_pkg::ST_EMIT)
    else $error("digest byte presented outside the emit phase");

  a_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == md5_pkg::ST_LOAD |-> pos_q == '0)
    else $error("compression started on a partial block");

  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == md5_pkg::ST_FOLD |-> $past(rnd_q) == md5_pkg::LastRound)
    else $error("fold without all 64 rounds");

  a_emit_only_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == md5_pkg::ST_EMIT |-> padding_q && !spill_q)
    else $error("digest emitted before the length block");

endmodule

// ===== dv/tb_md5_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_message_digest
// Self-checking bench for the byte-stream MD5 block. A digest ledger keeps
// its own MD5 state, folds in every accepted input word and queues the 16
// digest bytes that an end word produces. Each accepted output word is
// checked against the oldest queued byte. Both sides idle at random.
// ----------------------------------------------------------------------------

class md5_digest_ledger;
  logic [31:0]        chain [4];
  logic [7:0]         blk [64];
  logic [5:0]         fill;
  logic [63:0]        nbits;
  logic [31:0]        sine_k [64];
  int                 rot_by [16];
  md5_pkg::out_word_t digest_due [$];
  int                 errors;

  function new();
    real s;
    // T[i] = floor(2^32 * |sin(i + 1)|), as the hash defines it
    for (int i = 0; i < 64; i++) begin
      s = $sin(real'(i + 1));
      if (s < 0.0) begin
        s = -s;
      end
      sine_k[i] = 32'(longint'($floor(s * 4294967296.0)));
    end
    rot_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    foreach (blk[i]) blk[i] = 8'h00;
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    fill     = 6'd0;
    nbits    = 64'd0;
  endfunction

  // one 64-round pass over the block store
  function void compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g, sh;
    for (int k = 0; k < 16; k++) begin
      m[k] = {blk[4*k+3], blk[4*k+2], blk[4*k+1], blk[4*k]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sh = rot_by[(r / 16) * 4 + r % 4];
      t  = a + f + sine_k[r] + m[g];
      t  = (t << sh) | (t >> (32 - sh));
      a  = d;
      d  = c;
      c  = b;
      b  = b + t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // fold in one accepted input word; an end word queues the digest
  function void absorb_word(md5_pkg::in_word_t w);
    md5_pkg::out_word_t o;
    int p;
    if (w.kind == md5_pkg::KindData) begin
      blk[fill] = w.data_byte;
      nbits     = nbits + 64'd8;
      fill      = fill + 6'd1;
      if (fill == 6'd0) begin
        compress();
      end
    end else begin
      p      = int'(fill);
      blk[p] = 8'h80;
      p++;
      // no room for the length behind the pad byte: extra block
      if (p > 56) begin
        while (p < 64) begin
          blk[p] = 8'h00;
          p++;
        end
        compress();
        p = 0;
      end
      while (p < 56) begin
        blk[p] = 8'h00;
        p++;
      end
      for (int k = 0; k < 8; k++) begin
        blk[56 + k] = nbits[8*k +: 8];
      end
      compress();
      for (int k = 0; k < 16; k++) begin
        o.digest_byte = chain[k / 4][8 * (k % 4) +: 8];
        o.last        = (k == 15);
        digest_due.push_back(o);
      end
      restart();
    end
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task check_digest_byte(md5_pkg::out_word_t got);
    md5_pkg::out_word_t want;
    if (digest_due.size() == 0) begin
      report($sformatf("unexpected output word %02h last=%0b", got.digest_byte, got.last));
    end else begin
      want = digest_due.pop_front();
      if (got.digest_byte !== want.digest_byte) begin
        report($sformatf("digest byte got %02h want %02h", got.digest_byte, want.digest_byte));
      end
      if (got.last !== want.last) begin
        report($sformatf("last flag got %0b want %0b", got.last, want.last));
      end
    end
  endtask
endclass

module tb_md5_message_digest;

  localparam int CLK_HALF     = 2;       // 4 ns period
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_WORDS = 90;      // rough size of the random part
  localparam int HOLD_CYCLES  = 400;     // long output stall
  localparam int TAIL_CYCLES  = 300;     // two compressions plus padding, with margin
  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest clean run

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  md5_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  md5_pkg::out_word_t out_word;

  md5_digest_ledger ledger = new();

  // set by the stimulus, cleared by the sink once its long stall is over
  bit hold_req = 1'b0;
  int words_sent = 0;

  md5_message_digest u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Output checker: samples pre-edge values at each rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_digest_byte(out_word);
    end
  end

  // Sink: random ready pattern, long runs of ready now and then, and one
  // long stall on request so the block backs up into its input.
  initial begin : sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(40, 120)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        gap = idle_span();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Offer one word and hold it until accepted; then, for a nonzero gap, drop
  // valid and idle for the gap. With gap 0 valid stays high for the next word.
  task automatic send_word(input logic kind, input logic [7:0] data, input int gap);
    md5_pkg::in_word_t w;
    w.kind      = kind;
    w.data_byte = data;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.absorb_word(w);
    words_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A message of len random bytes and its end word. The end word carries a
  // random byte too, which the block must ignore.
  task automatic send_message(input int len, input bit burst, input int end_gap);
    for (int i = 0; i < len; i++) begin
      send_word(md5_pkg::KindData, 8'($urandom_range(0, 255)), burst ? 0 : idle_span());
    end
    send_word(md5_pkg::KindEnd, 8'($urandom_range(0, 255)), end_gap);
  endtask

  // Sender pause: valid is low here, wait until every digest byte is back.
  task automatic wait_digests_out();
    while (ledger.digest_due.size() != 0) @(posedge clk);
  endtask

  // Watchdog: a hung handshake or a missing digest byte ends up here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int len;
    int random_start;
    int msg_idx;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // empty message straight after reset
    send_word(md5_pkg::KindEnd, 8'h00, 1);
    wait_digests_out();
    // single byte at both extremes; the end word's ignored byte all ones
    send_word(md5_pkg::KindData, 8'h00, 0);
    send_word(md5_pkg::KindEnd, 8'hff, 2);
    send_word(md5_pkg::KindData, 8'hff, 0);
    send_word(md5_pkg::KindEnd, 8'h00, 0);
    // alternating bit patterns
    send_word(md5_pkg::KindData, 8'h55, 0);
    send_word(md5_pkg::KindData, 8'haa, 1);
    send_word(md5_pkg::KindData, 8'h0f, 0);
    send_word(md5_pkg::KindData, 8'hf0, 0);
    send_word(md5_pkg::KindEnd, 8'h5a, 0);
    // two empty messages back to back: the chain must restart cleanly
    send_word(md5_pkg::KindEnd, 8'h00, 0);
    send_word(md5_pkg::KindEnd, 8'hff, 0);
    // "abc"
    send_word(md5_pkg::KindData, 8'h61, 0);
    send_word(md5_pkg::KindData, 8'h62, 0);
    send_word(md5_pkg::KindData, 8'h63, 0);
    send_word(md5_pkg::KindEnd, 8'h00, 1);
    wait_digests_out();

    // ---- random part ----
    // The bit count wrapping at 2^64 needs 2^61 bytes and is out of reach.
    random_start = words_sent;
    // pad spills into a second block
    send_message($urandom_range(56, 63), 1'b0, idle_span());
    msg_idx = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       len = 55;                     // largest length without spill
        1:       len = 64;                     // exact block, length in its own block
        default: len = $urandom_range(0, 12);
      endcase
      // a long output stall while the sender keeps going
      if (msg_idx == 2) begin
        hold_req = 1'b1;
      end
      if (msg_idx == 5) begin
        // full stop until all digests are out
        send_message(len, $urandom_range(0, 3) == 0, 1);
        wait_digests_out();
      end else begin
        send_message(len, $urandom_range(0, 3) == 0, idle_span());
      end
      msg_idx++;
    end
    in_valid <= 1'b0;

    // ---- drain ----
    wait_digests_out();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
